// File: src/sdrd_pkg.sv
// Shared types and constants for the scroll direction regime detector.
package sdrd_pkg;

  // Confirmed or pending direction, coded as a 2-bit signed value
  typedef enum logic [1:0] {
    RG_NONE = 2'b00,
    RG_DOWN = 2'b01,
    RG_UP   = 2'b11
  } regime_t;

  // Input actions
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_RESET  = 1'b1;

  // Field widths
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned DIST_W   = 24;
  localparam int unsigned BUF_W    = 26;

  // Time limits in 1/16 ms ticks: 200 ms stale, 4 ms minimum spacing
  localparam logic [TIME_W-1:0] STALE_TICKS = 32'd3200;
  localparam logic [TIME_W-1:0] MIN_TICKS   = 32'd64;

  // Agreeing samples needed before a direction is confirmed (2 or 3)
  localparam logic [1:0] CONFIRM_SAMPLES = 2'd2;

  // One input transaction
  typedef struct packed {
    logic                       action;
    logic signed [OFFSET_W-1:0] scroll_offset;
    logic        [TIME_W-1:0]   time_now;
    logic        [DIST_W-1:0]   draw_distance;
  } item_t;

  // Pipeline control shared by the tracker and the output stage
  typedef struct packed {
    logic advance;  // output register may load this cycle
    logic step;     // the held item is processed this cycle
  } pipe_ctl_t;

  // Configuration write
  typedef struct packed {
    logic write;
    logic value;
  } cfg_wr_t;

endpackage

// File: src/sdrd_tracker.sv
// Velocity tracker: baseline, classification and regime confirmation state.
module sdrd_tracker (
  input  logic               clk,
  input  logic               rst,
  input  sdrd_pkg::pipe_ctl_t ctl,
  input  sdrd_pkg::cfg_wr_t  cfg,
  input  sdrd_pkg::item_t    item,
  output sdrd_pkg::regime_t  regime_out
);
  import sdrd_pkg::*;

  // State registers
  logic                       en;
  logic                       has_baseline;
  logic        [TIME_W-1:0]   baseline_time;
  logic signed [OFFSET_W-1:0] baseline_offset;
  regime_t                    current_regime;
  regime_t                    pending_direction;
  logic        [1:0]          pending_count;

  // Next values for one processed item
  logic                       has_baseline_next;
  logic        [TIME_W-1:0]   baseline_time_next;
  logic signed [OFFSET_W-1:0] baseline_offset_next;
  regime_t                    current_regime_next;
  regime_t                    pending_direction_next;
  logic        [1:0]          pending_count_next;

  // Classification terms
  logic        [TIME_W-1:0]   dt;
  logic                       stale;
  logic                       usable;
  logic                       take_baseline;
  logic                       sampled;
  logic signed [OFFSET_W:0]   delta;
  logic        [OFFSET_W:0]   mag;
  logic        [OFFSET_W+4:0] mag_x20;
  logic        [OFFSET_W+4:0] dt_x3;
  logic                       fast;
  regime_t                    candidate;
  logic        [1:0]          count_inc;

  // Time gap and offset change against the baseline
  assign dt      = item.time_now - baseline_time;
  assign stale   = dt > STALE_TICKS;
  assign usable  = dt >= MIN_TICKS;
  assign delta   = {item.scroll_offset[OFFSET_W-1], item.scroll_offset}
                 - {baseline_offset[OFFSET_W-1], baseline_offset};
  assign mag     = delta[OFFSET_W] ? (OFFSET_W+1)'(0) - delta : delta;

  // Cross-multiplied speed test: 20*|d| >= 3*dt
  assign mag_x20 = {mag, 4'b0} + {2'b0, mag, 2'b0};
  assign dt_x3   = {5'b0, dt} + {4'b0, dt, 1'b0};
  assign fast    = mag_x20 >= dt_x3;

  assign take_baseline = !has_baseline || stale || usable;
  assign sampled       = has_baseline && (stale || usable);
  assign candidate     = (has_baseline && !stale && fast)
                       ? (delta[OFFSET_W] ? RG_UP : RG_DOWN) : RG_NONE;
  assign count_inc     = pending_count + 2'd1;

  // Work out the state after the held item
  always_comb begin
    has_baseline_next      = has_baseline;
    baseline_time_next     = baseline_time;
    baseline_offset_next   = baseline_offset;
    current_regime_next    = current_regime;
    pending_direction_next = pending_direction;
    pending_count_next     = pending_count;
    if (item.action == ACT_RESET) begin
      has_baseline_next      = 1'b0;
      baseline_offset_next   = '0;
      current_regime_next    = RG_NONE;
      pending_direction_next = RG_NONE;
      pending_count_next     = 2'd0;
    end else if (en && (item.scroll_offset != baseline_offset)) begin
      if (take_baseline) begin
        has_baseline_next    = 1'b1;
        baseline_time_next   = item.time_now;
        baseline_offset_next = item.scroll_offset;
      end
      if (sampled) begin
        if (candidate == current_regime) begin
          pending_direction_next = RG_NONE;
          pending_count_next     = 2'd0;
        end else if ((candidate == RG_NONE) || (current_regime != RG_NONE)) begin
          current_regime_next    = RG_NONE;
          pending_direction_next = candidate;
          pending_count_next     = (candidate == RG_NONE) ? 2'd0 : 2'd1;
        end else if (candidate == pending_direction) begin
          pending_count_next = count_inc;
          if (count_inc >= CONFIRM_SAMPLES) begin
            current_regime_next    = candidate;
            pending_direction_next = RG_NONE;
            pending_count_next     = 2'd0;
          end
        end else begin
          pending_direction_next = candidate;
          pending_count_next     = 2'd1;
        end
      end
    end
  end

  // Report no direction while tracking is off
  assign regime_out = en ? current_regime_next : RG_NONE;

  // Hold state; a changing config write clears the tracker
  always_ff @(posedge clk) begin
    if (rst) begin
      en                <= 1'b0;
      has_baseline      <= 1'b0;
      baseline_time     <= '0;
      baseline_offset   <= '0;
      current_regime    <= RG_NONE;
      pending_direction <= RG_NONE;
      pending_count     <= 2'd0;
    end else if (cfg.write && (cfg.value != en)) begin
      en                <= cfg.value;
      has_baseline      <= 1'b0;
      current_regime    <= RG_NONE;
      pending_direction <= RG_NONE;
      pending_count     <= 2'd0;
    end else if (ctl.step) begin
      has_baseline      <= has_baseline_next;
      baseline_time     <= baseline_time_next;
      baseline_offset   <= baseline_offset_next;
      current_regime    <= current_regime_next;
      pending_direction <= pending_direction_next;
      pending_count     <= pending_count_next;
    end
  end

  // A pending count needs a pending direction
  a_count_has_dir: assert property (@(posedge clk) disable iff (rst)
    (pending_count != 2'd0) |-> (pending_direction != RG_NONE))
    else $error("pending count without pending direction");

  // A confirmed regime leaves nothing pending
  a_confirmed_clean: assert property (@(posedge clk) disable iff (rst)
    (current_regime != RG_NONE) |-> ((pending_direction == RG_NONE) && (pending_count == 2'd0)))
    else $error("pending state alongside confirmed regime");

  // Toggling the enable clears the tracker
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    (cfg.write && (cfg.value != en)) |=> (!has_baseline && (current_regime == RG_NONE)))
    else $error("tracker not cleared by enable change");

  // A reset action drops the baseline and regime
  a_action_clears: assert property (@(posedge clk) disable iff (rst)
    (ctl.step && !cfg.write && (item.action == ACT_RESET))
      |=> (!has_baseline && (baseline_offset == '0) && (current_regime == RG_NONE)))
    else $error("reset action did not clear tracker");

endmodule

// File: src/sdrd_out_stage.sv
// Output register: buffer sizing from the regime and the result handshake.
module sdrd_out_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  sdrd_pkg::pipe_ctl_t               ctl,
  input  logic                              item_valid,
  input  sdrd_pkg::regime_t                 regime_in,
  input  logic [sdrd_pkg::DIST_W-1:0]       draw_distance,
  output logic                              out_valid,
  output logic signed [1:0]                 regime,
  output logic [sdrd_pkg::BUF_W-1:0]        top_buffer,
  output logic [sdrd_pkg::BUF_W-1:0]        bottom_buffer
);
  import sdrd_pkg::*;

  logic [BUF_W-1:0] dd_x1;
  logic [BUF_W-1:0] dd_x2;
  logic [BUF_W-1:0] dd_x3;
  logic [BUF_W-1:0] top_next;
  logic [BUF_W-1:0] bottom_next;
  regime_t          regime_q;

  // Multiples of the draw distance, already in 1/16 px
  assign dd_x1 = {2'b0, draw_distance};
  assign dd_x2 = {1'b0, draw_distance, 1'b0};
  assign dd_x3 = dd_x1 + dd_x2;

  // Pick the buffers: asymmetric for a confirmed direction, equal otherwise
  always_comb begin
    unique case (regime_in)
      RG_DOWN: begin
        top_next    = dd_x1;
        bottom_next = dd_x3;
      end
      RG_UP: begin
        top_next    = dd_x3;
        bottom_next = dd_x1;
      end
      default: begin
        top_next    = dd_x2;
        bottom_next = dd_x2;
      end
    endcase
  end

  // Advance the result valid whenever the slot frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.advance) begin
      out_valid <= item_valid;
    end
  end

  // Load the result payload with the processed item
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      regime_q      <= regime_in;
      top_buffer    <= top_next;
      bottom_buffer <= bottom_next;
    end
  end

  assign regime = $signed(regime_q);

endmodule

// File: src/scroll_direction_regime_detector.sv
// Top level of the scroll direction regime detector.
// Throughput: one transaction per cycle while the output is not stalled.
// Input register feeds tracker logic, which feeds the output register.
// Reset (rst, synchronous): tracking disabled, baseline and regime cleared, pipeline empty.
// Config writes are always ready and take effect in the cycle after they are written.
module scroll_direction_regime_detector (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 directional_enabled,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 action,
  input  logic signed [sdrd_pkg::OFFSET_W-1:0] scroll_offset,
  input  logic [sdrd_pkg::TIME_W-1:0]          time_now,
  input  logic [sdrd_pkg::DIST_W-1:0]          draw_distance,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [1:0]                    regime,
  output logic [sdrd_pkg::BUF_W-1:0]           top_buffer,
  output logic [sdrd_pkg::BUF_W-1:0]           bottom_buffer
);
  import sdrd_pkg::*;

  item_t     in_q;
  logic      in_q_valid;
  logic      in_load;
  pipe_ctl_t ctl;
  cfg_wr_t   cfg;
  regime_t   regime_step;

  // Pipeline handshake
  assign ctl.advance = !out_valid || !out_stall;
  assign ctl.step    = in_q_valid && ctl.advance;
  assign in_stall    = in_q_valid && !ctl.advance;
  assign in_load     = in_valid && !in_stall;

  // Config port
  assign cfg_ready = 1'b1;
  assign cfg.write = cfg_valid && cfg_ready;
  assign cfg.value = directional_enabled;

  // Hold the input transaction valid until it is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_load) begin
      in_q_valid <= 1'b1;
    end else if (ctl.step) begin
      in_q_valid <= 1'b0;
    end
  end

  // Capture the input payload
  always_ff @(posedge clk) begin
    if (in_load) begin
      in_q.action        <= action;
      in_q.scroll_offset <= scroll_offset;
      in_q.time_now      <= time_now;
      in_q.draw_distance <= draw_distance;
    end
  end

  sdrd_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cfg        (cfg),
    .item       (in_q),
    .regime_out (regime_step)
  );

  sdrd_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .item_valid    (in_q_valid),
    .regime_in     (regime_step),
    .draw_distance (in_q.draw_distance),
    .out_valid     (out_valid),
    .regime        (regime),
    .top_buffer    (top_buffer),
    .bottom_buffer (bottom_buffer)
  );

endmodule

// File: dv/scroll_direction_regime_detector_tb.sv
// Testbench for the scroll direction regime detector: random handshakes, predicted buffers.
`timescale 1ns / 1ps

module scroll_direction_regime_detector_tb;
  import sdrd_pkg::*;

  // One expected result: confirmed regime and the two buffers
  typedef struct {
    regime_t              regime;
    logic [BUF_W-1:0]     top;
    logic [BUF_W-1:0]     bottom;
  } buffer_set_t;

  // Tracks the regime the block should report and checks every result against it
  class regime_scoreboard;
    bit               tracking = 1'b0;
    bit               has_base = 1'b0;
    logic [TIME_W-1:0]   base_time = '0;
    logic [OFFSET_W-1:0] base_off  = '0;
    regime_t          cur_dir  = RG_NONE;
    regime_t          pend_dir = RG_NONE;
    logic [1:0]       pend_cnt = '0;
    int               errors   = 0;
    buffer_set_t      due_buffers[$];

    function void clear_tracker();
      has_base = 1'b0;
      cur_dir  = RG_NONE;
      pend_dir = RG_NONE;
      pend_cnt = '0;
    endfunction

    // Apply an enable write; only a change of value clears the tracker
    function void set_tracking(bit en);
      if (en != tracking) begin
        tracking = en;
        clear_tracker();
      end
    endfunction

    // Measure velocity against the baseline and advance the confirmation counter
    function void track_sample(logic [OFFSET_W-1:0] off, logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] dt;
      longint            d;
      longint            mag;
      regime_t           cand;
      bit                sampled;
      bit                moves;
      if (off == base_off) return;
      cand    = RG_NONE;
      sampled = 1'b0;
      moves   = 1'b1;
      if (has_base) begin
        dt = now - base_time;
        if (dt > STALE_TICKS) begin
          sampled = 1'b1;
        end else if (dt >= MIN_TICKS) begin
          d   = longint'($signed(off)) - longint'($signed(base_off));
          mag = (d < 0) ? -d : d;
          if (mag * 20 >= longint'(dt) * 3) cand = (d > 0) ? RG_DOWN : RG_UP;
          sampled = 1'b1;
        end else begin
          moves = 1'b0;
        end
      end
      if (moves) begin
        has_base  = 1'b1;
        base_time = now;
        base_off  = off;
      end
      if (!sampled) return;
      if (cand == cur_dir) begin
        pend_dir = RG_NONE;
        pend_cnt = '0;
      end else if (cand == RG_NONE || cur_dir != RG_NONE) begin
        cur_dir  = RG_NONE;
        pend_dir = cand;
        pend_cnt = (cand == RG_NONE) ? 2'd0 : 2'd1;
      end else if (cand == pend_dir) begin
        pend_cnt = pend_cnt + 2'd1;
        if (pend_cnt >= CONFIRM_SAMPLES) begin
          cur_dir  = cand;
          pend_dir = RG_NONE;
          pend_cnt = '0;
        end
      end else begin
        pend_dir = cand;
        pend_cnt = 2'd1;
      end
    endfunction

    // Update the tracker for an accepted transaction and queue its expected buffers
    function void note_sample(logic act, logic [OFFSET_W-1:0] off, logic [TIME_W-1:0] now,
                              logic [DIST_W-1:0] dd);
      buffer_set_t      exp_set;
      logic [BUF_W-1:0] base;
      if (act == ACT_RESET) begin
        clear_tracker();
        base_off = '0;
      end else if (tracking) begin
        track_sample(off, now);
      end
      base = {2'b00, dd};
      exp_set.regime = tracking ? cur_dir : RG_NONE;
      case (exp_set.regime)
        RG_DOWN: begin
          exp_set.top    = base;
          exp_set.bottom = BUF_W'(base * 3);
        end
        RG_UP: begin
          exp_set.top    = BUF_W'(base * 3);
          exp_set.bottom = base;
        end
        default: begin
          exp_set.top    = BUF_W'(base * 2);
          exp_set.bottom = BUF_W'(base * 2);
        end
      endcase
      due_buffers.push_back(exp_set);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_buffers(logic [1:0] rg, logic [BUF_W-1:0] top,
                                logic [BUF_W-1:0] bottom);
      buffer_set_t exp_set;
      if (due_buffers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: regime %0d top %0d bottom %0d",
                 $time, $signed(rg), top, bottom);
        return;
      end
      exp_set = due_buffers.pop_front();
      if (rg !== exp_set.regime) begin
        errors++;
        $display("%0t: regime expected %0d actual %0d", $time, $signed(exp_set.regime),
                 $signed(rg));
      end
      if (top !== exp_set.top) begin
        errors++;
        $display("%0t: top_buffer expected %0d actual %0d", $time, exp_set.top, top);
      end
      if (bottom !== exp_set.bottom) begin
        errors++;
        $display("%0t: bottom_buffer expected %0d actual %0d", $time, exp_set.bottom, bottom);
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT    = 300000;
  localparam int ITEMS_PER_PASS = 75;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic                       directional_enabled;
  logic                       in_valid;
  logic                       in_stall;
  logic                       action;
  logic signed [OFFSET_W-1:0] scroll_offset;
  logic [TIME_W-1:0]          time_now;
  logic [DIST_W-1:0]          draw_distance;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [1:0]          regime;
  logic [BUF_W-1:0]           top_buffer;
  logic [BUF_W-1:0]           bottom_buffer;

  regime_scoreboard sb = new();

  int                  cycle_count = 0;
  bit                  in_calm     = 1'b0;
  bit                  out_calm    = 1'b0;
  logic [OFFSET_W-1:0] gen_off     = '0;
  logic [TIME_W-1:0]   gen_time    = '0;
  bit                  gen_up      = 1'b0;
  bit                  pass_enable[6] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  scroll_direction_regime_detector DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("scroll_direction_regime_detector_tb: FAIL");
      $finish;
    end
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_buffers(regime, top_buffer, bottom_buffer);
  end

  // Stall the result side for a random hold before each transaction
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
      hold = out_calm ? 0 : $urandom_range(0, 19);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Drive one input transaction after a random gap and hold it until accepted
  task automatic send_item(input logic act, input logic [OFFSET_W-1:0] off,
                           input logic [TIME_W-1:0] now, input logic [DIST_W-1:0] dd);
    int unsigned gap;
    if ($urandom_range(0, 19) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    scroll_offset <= off;
    time_now      <= now;
    draw_distance <= dd;
    do @(posedge clk); while (in_stall);
    sb.note_sample(act, off, now, dd);
  endtask

  // Write the enable register; the block is idle here
  task automatic write_enable(input logic en);
    cfg_valid           <= 1'b1;
    directional_enabled <= en;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_tracking(en);
  endtask

  // Drop valid and wait until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due_buffers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly steady scrolling with near-threshold speeds, plus resets and noise
  task automatic send_random_item();
    int unsigned pick;
    longint      dt_l;
    longint      mag;
    logic [DIST_W-1:0] dd;
    dd   = ($urandom_range(0, 3) == 0) ? DIST_W'($urandom) : DIST_W'($urandom_range(0, 4000));
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_item(ACT_RESET, $urandom, $urandom, dd);
    end else if (pick < 10) begin
      gen_off  = $urandom;
      gen_time = $urandom;
      send_item(ACT_SAMPLE, gen_off, gen_time, dd);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 8)       dt_l = $urandom_range(0, 63);
      else if (pick < 14) dt_l = 3200 + $urandom_range(1, 2000);
      else if (pick < 16) dt_l = -longint'($urandom_range(1, 1000));
      else if (pick < 24) begin
        case ($urandom_range(0, 3))
          0:       dt_l = 63;
          1:       dt_l = 64;
          2:       dt_l = 3200;
          default: dt_l = 3201;
        endcase
      end else begin
        dt_l = $urandom_range(64, 3200);
      end
      gen_time = gen_time + TIME_W'(dt_l);
      if ($urandom_range(0, 9) == 0) gen_up = !gen_up;
      pick = $urandom_range(0, 99);
      if (pick < 8)                    mag = 0;
      else if (pick < 35 && dt_l > 0)  mag = (3 * dt_l + 19) / 20 + $urandom_range(0, 2) - 1;
      else                             mag = $urandom_range(1, 50000);
      gen_off = OFFSET_W'(longint'(gen_off) + (gen_up ? -mag : mag));
      send_item(ACT_SAMPLE, gen_off, gen_time, dd);
    end
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_valid           = 1'b0;
    directional_enabled = 1'b0;
    in_valid            = 1'b0;
    action              = ACT_SAMPLE;
    scroll_offset       = '0;
    time_now            = '0;
    draw_distance       = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Same value as reset, then enable tracking
    write_enable(1'b0);
    write_enable(1'b1);

    // Unchanged offset before any baseline, then first sample and too-close sample
    send_item(ACT_SAMPLE, 32'd0, 32'd100, 24'hFFFFFF);
    send_item(ACT_SAMPLE, 32'd1000, 32'd200, 24'd0);
    send_item(ACT_SAMPLE, 32'd1010, 32'd263, 24'd7);
    // Confirm downward at the minimum spacing, hold it, then turn upward
    send_item(ACT_SAMPLE, 32'd2000, 32'd264, 24'd7);
    send_item(ACT_SAMPLE, 32'd3000, 32'd400, 24'd7);
    send_item(ACT_SAMPLE, 32'd4000, 32'd500, 24'hFFFFFF);
    send_item(ACT_SAMPLE, 32'd3000, 32'd600, 24'd9);
    send_item(ACT_SAMPLE, 32'd2000, 32'd700, 24'hFFFFFF);
    // Slow drift drops the regime; stale gap; threshold hit and miss at the stale edge
    send_item(ACT_SAMPLE, 32'd1999, 32'd800, 24'd9);
    send_item(ACT_SAMPLE, 32'd5000, 32'd4001, 24'd11);
    send_item(ACT_SAMPLE, 32'd5480, 32'd7201, 24'd11);
    send_item(ACT_SAMPLE, 32'd5959, 32'd10401, 24'd11);
    // Offset extremes
    send_item(ACT_SAMPLE, 32'h80000000, 32'd10500, 24'd13);
    send_item(ACT_SAMPLE, 32'h7FFFFFFF, 32'd10600, 24'd13);
    send_item(ACT_SAMPLE, 32'h7FFFFFFE, 32'd10700, 24'd13);
    // Time going backwards, then a wrap of the timestamp
    send_item(ACT_SAMPLE, 32'd100, 32'd5, 24'd15);
    send_item(ACT_SAMPLE, 32'd200, 32'hFFFFFFF0, 24'd15);
    send_item(ACT_SAMPLE, 32'd1200, 32'h00000030, 24'd15);
    send_item(ACT_SAMPLE, 32'd2200, 32'h000000A0, 24'hFFFFFF);
    // Reset action, then offset zero is ignored again
    send_item(ACT_RESET, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF);
    send_item(ACT_SAMPLE, 32'd0, 32'h00000200, 24'd3);
    send_item(ACT_SAMPLE, 32'hFFFFFFFF, 32'h00000300, 24'd3);
    drain();

    // Tracking off: samples and reset actions report no regime
    write_enable(1'b0);
    send_item(ACT_SAMPLE, 32'd5000, 32'h00000400, 24'd21);
    send_item(ACT_RESET, 32'd0, 32'h00000500, 24'd21);
    drain();

    // Random passes across several enable settings
    foreach (pass_enable[p]) begin
      write_enable(pass_enable[p]);
      repeat (ITEMS_PER_PASS) send_random_item();
      drain();
    end

    if (sb.errors == 0) begin
      $display("scroll_direction_regime_detector_tb: PASS");
    end else begin
      $display("scroll_direction_regime_detector_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/sdrd_pkg.sv
src/sdrd_tracker.sv
src/sdrd_out_stage.sv
src/scroll_direction_regime_detector.sv
dv/scroll_direction_regime_detector_tb.sv
